@@ rtl/core/slt_pkg.sv @@
// Shared types and constants for the sorted list table core.
// Used by slt_cell and sorted_list_table_core; no dependencies.
package slt_pkg;

    localparam int SLT_CAPACITY = 16;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_CLR  = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [31:0] value;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] position;
        logic [4:0] entry_count;
    } t_result;

    typedef struct packed {
        logic       cmp;
        logic [1:0] op;
    } t_cell_ctl;

endpackage

@@ rtl/core/slt_cell.sv @@
// One cell of the sorted chain: holds one entry, its occupied bit and compare flags.
// Depends on slt_pkg.
module slt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slt_pkg::t_cell_ctl i_ctl,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_left_entry,
    input  logic               i_left_occ,
    input  logic               i_left_le,
    input  logic signed [31:0] i_right_entry,
    input  logic               i_right_occ,
    output logic signed [31:0] o_entry,
    output logic               o_occ,
    output logic               o_le,
    output logic               o_lt,
    output logic               o_eq
);

    logic signed [31:0] r_entry, n_entry;
    logic               r_occ, n_occ;
    logic               r_le, r_lt, r_eq;

    // Capture compare flags against the pending request value.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_le <= r_occ && (r_entry <= i_value);
            r_lt <= r_occ && (r_entry <  i_value);
            r_eq <= r_occ && (r_entry == i_value);
        end
    end

    always_comb begin
        n_entry = r_entry;
        n_occ   = r_occ;
        unique case (i_ctl.op)
            slt_pkg::CELL_INS: begin
                // Cells past the insert point shift right by one.
                if (!r_le) begin
                    n_entry = i_left_le ? i_value : i_left_entry;
                    n_occ   = i_left_occ;
                end
            end
            slt_pkg::CELL_DEL: begin
                // Cells from the first match on shift left by one.
                if (!r_lt) begin
                    n_entry = i_right_entry;
                    n_occ   = i_right_occ;
                end
            end
            slt_pkg::CELL_CLR: begin
                n_occ = 1'b0;
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_entry = r_entry;
    assign o_occ   = r_occ;
    assign o_le    = r_le;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

@@ rtl/core/slt_onehot_enc.sv @@
// One-hot (or all-zero) vector to binary index encoder.
// No dependencies.
module slt_onehot_enc #(
    parameter int N  = 16,
    parameter int IW = $clog2(N)
) (
    input  logic [N-1:0]  i_onehot,
    output logic [IW-1:0] o_index
);

    always_comb begin
        o_index = '0;
        for (int i = 0; i < N; i++) begin
            if (i_onehot[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end

endmodule

@@ rtl/core/sorted_list_table_core.sv @@
// Sorted list table core: a chain of compare-and-shift cells holding signed values.
// Depends on slt_pkg, slt_cell and slt_onehot_enc.
//
// Usage:
//   Request channel: i_in_valid / o_in_stall carry a t_request (req_type, value).
//   A transfer happens at a rising edge with valid high and stall low.
//   Result channel: o_out_valid / i_out_stall carry a t_result (status, found,
//   position, entry_count); exactly one result per request, in request order.
//   Steps: a request taken in the accept step has its compare flags registered
//   in the compare step, and its result is registered when the update step ends.
//   The cell chain works on one request at a time through the accept, compare
//   and update steps, so no new request is taken until the last one is done.
//   A result left waiting in the output register does not block the next
//   request; that request holds in the update step until the waiting result
//   is taken, and the cells do not change before then.
//   Reset (i_rst_n low, synchronous) empties the table and drops any pending
//   result; cell contents are left as they are and are never read while empty.
module sorted_list_table_core #(
    parameter int CAPACITY = slt_pkg::SLT_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  slt_pkg::t_request i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output slt_pkg::t_result  o_out_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_req;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid;
    slt_pkg::t_result   r_out, n_out;

    logic signed [31:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_occ, w_le, w_lt, w_eq;
    logic [CAPACITY-1:0] w_bnd_le, w_bnd_lt;
    logic [IW-1:0]       w_ins_idx, w_match_idx;
    logic [IW+3:0]       w_ins_ext, w_match_ext;
    logic [CW+4:0]       w_count_ext;

    slt_pkg::t_cell_ctl w_ctl;
    logic               w_accept, w_go, w_full, w_found;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    // Finish the update only when the output register is free or draining.
    assign w_go     = (r_state == ST_UPD) && (!r_out_valid || !i_out_stall);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_found  = |w_eq;

    // Cell chain: each cell sees its neighbors' entries and flags.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] l_entry, r_ent;
        logic               l_occ, l_le, r_occ_nb;
        if (g == 0) begin : g_head
            assign l_entry = r_value;
            assign l_occ   = 1'b1;
            assign l_le    = 1'b1;
        end else begin : g_mid
            assign l_entry = w_entry[g-1];
            assign l_occ   = w_occ[g-1];
            assign l_le    = w_le[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign r_ent    = r_value;
            assign r_occ_nb = 1'b0;
        end else begin : g_body
            assign r_ent    = w_entry[g+1];
            assign r_occ_nb = w_occ[g+1];
        end

        slt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_value      (r_value),
            .i_left_entry (l_entry),
            .i_left_occ   (l_occ),
            .i_left_le    (l_le),
            .i_right_entry(r_ent),
            .i_right_occ  (r_occ_nb),
            .o_entry      (w_entry[g]),
            .o_occ        (w_occ[g]),
            .o_le         (w_le[g]),
            .o_lt         (w_lt[g]),
            .o_eq         (w_eq[g])
        );

        // Boundaries where the sorted prefixes of entries <= and < the request value end.
        assign w_bnd_le[g] = l_le & ~w_le[g];
        if (g == 0) begin : g_lt_head
            assign w_bnd_lt[g] = ~w_lt[g];
        end else begin : g_lt_mid
            assign w_bnd_lt[g] = w_lt[g-1] & ~w_lt[g];
        end
    end

    slt_onehot_enc #(.N(CAPACITY), .IW(IW)) u_ins_enc (
        .i_onehot(w_bnd_le),
        .o_index (w_ins_idx)
    );

    slt_onehot_enc #(.N(CAPACITY), .IW(IW)) u_match_enc (
        .i_onehot(w_bnd_lt),
        .o_index (w_match_idx)
    );

    assign w_ins_ext   = {4'b0, w_ins_idx};
    assign w_match_ext = {4'b0, w_match_idx};
    assign w_count_ext = {5'b0, n_count};

    // Decide the cell operation and the result of the pending request.
    always_comb begin
        w_ctl.cmp = (r_state == ST_CMP);
        w_ctl.op  = slt_pkg::CELL_HOLD;
        n_count   = r_count;
        n_out     = '0;
        n_state   = r_state;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        unique case (r_req)
            slt_pkg::REQ_INSERT: begin
                n_out.found = w_found;
                if (w_full) begin
                    n_out.status = slt_pkg::STAT_FULL;
                end else begin
                    n_out.position = w_ins_ext[3:0];
                    n_count        = CW'(r_count + 1'b1);
                    if (w_go) begin
                        w_ctl.op = slt_pkg::CELL_INS;
                    end
                end
            end
            slt_pkg::REQ_DELETE: begin
                if (w_found) begin
                    n_out.found    = 1'b1;
                    n_out.position = w_match_ext[3:0];
                    n_count        = CW'(r_count - 1'b1);
                    if (w_go) begin
                        w_ctl.op = slt_pkg::CELL_DEL;
                    end
                end else begin
                    n_out.status = slt_pkg::STAT_NOT_FOUND;
                end
            end
            slt_pkg::REQ_SEARCH: begin
                if (w_found) begin
                    n_out.found    = 1'b1;
                    n_out.position = w_match_ext[3:0];
                end else begin
                    n_out.status = slt_pkg::STAT_NOT_FOUND;
                end
            end
            slt_pkg::REQ_CLEAR: begin
                n_count = '0;
                if (w_go) begin
                    w_ctl.op = slt_pkg::CELL_CLR;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase

        n_out.entry_count = w_count_ext[4:0];
    end

    // Hold the request while it works through the chain.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_in_data.req_type;
            r_value <= i_in_data.value;
        end
        if (w_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_occ_matches_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ) == 32'(r_count))
        else $error("occupied cells disagree with entry count");

    a_insert_boundary : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> ($onehot0(w_bnd_le) && $onehot0(w_bnd_lt)))
        else $error("sorted boundary is not unique");

    a_result_posted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("finished request did not post a result");
`endif

endmodule
